// ===== hdl/edc_pkg.sv =====
// Shared constants for the edit distance engine.
// No dependencies; used by every module of the block.
package edc_pkg;

    localparam int CMD_W     = 2;
    localparam int SYMBOL_W  = 8;
    localparam int DIST_W    = 6;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    localparam int MAX_LEN_DEFAULT = 32;

    localparam logic [DIST_W-1:0] DIST_MAX = 6'd63;

    localparam logic [CMD_W-1:0] CMD_APPEND_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE       = 2'd2;

endpackage

// ===== hdl/edc_cell.sv =====
// One column of the edit distance sweep: holds a byte of the second string
// and its running cost. Depends on edc_pkg.
module edc_cell #(
    parameter int VW = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          init,
    input  logic [VW-1:0]                 init_value,
    input  logic                          load_sym,
    input  logic [edc_pkg::SYMBOL_W-1:0]  sym_in,
    input  logic                          vld_i,
    input  logic [edc_pkg::SYMBOL_W-1:0]  chr_i,
    input  logic [VW-1:0]                 left_i,
    input  logic [VW-1:0]                 diag_i,
    output logic                          vld_o,
    output logic [edc_pkg::SYMBOL_W-1:0]  chr_o,
    output logic [VW-1:0]                 cost_o,
    output logic [VW-1:0]                 diag_o
);
    import edc_pkg::*;

    logic                vld_reg;
    logic [SYMBOL_W-1:0] chr_reg;
    logic [SYMBOL_W-1:0] sym_reg;
    logic [VW-1:0]       val_reg;
    logic [VW-1:0]       old_reg;
    logic [VW:0]         up_cost;
    logic [VW:0]         left_cost;
    logic [VW:0]         diag_cost;
    logic [VW:0]         min_a;
    logic [VW:0]         val_next;

    always_comb begin
        up_cost   = {1'b0, val_reg} + 1'b1;
        left_cost = {1'b0, left_i} + 1'b1;
        diag_cost = {1'b0, diag_i} + {{VW{1'b0}}, (chr_i != sym_reg)};
        min_a     = (up_cost < left_cost) ? up_cost : left_cost;
        val_next  = (min_a < diag_cost) ? min_a : diag_cost;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (init) begin
            // drop rows of the previous sweep still moving down the chain
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_sym) begin
            sym_reg <= sym_in;
        end
        if (init) begin
            val_reg <= init_value;
        end else if (vld_i) begin
            // costs never exceed the string length, so the top bit is spare
            val_reg <= val_next[VW-1:0];
            old_reg <= val_reg;
            chr_reg <= chr_i;
        end
    end

    assign vld_o  = vld_reg;
    assign chr_o  = chr_reg;
    assign cost_o = val_reg;
    assign diag_o = old_reg;

endmodule

// ===== hdl/edc_chain.sv =====
// Row of edit distance cells, one per byte of the second string, with the
// byte load decode and the final cost select. Depends on edc_pkg, edc_cell.
module edc_chain #(
    parameter int MAX_LEN = edc_pkg::MAX_LEN_DEFAULT,
    parameter int VW      = $clog2(MAX_LEN + 1),
    parameter int IW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          init,
    input  logic                          load_en,
    input  logic [IW-1:0]                 load_idx,
    input  logic [edc_pkg::SYMBOL_W-1:0]  load_sym,
    input  logic                          row_vld,
    input  logic [edc_pkg::SYMBOL_W-1:0]  row_chr,
    input  logic [VW-1:0]                 row_left,
    input  logic [VW-1:0]                 row_diag,
    input  logic [IW-1:0]                 sel_idx,
    output logic [VW-1:0]                 sel_cost
);
    import edc_pkg::*;

    logic                vld_link  [MAX_LEN+1];
    logic [SYMBOL_W-1:0] chr_link  [MAX_LEN+1];
    logic [VW-1:0]       cost_link [MAX_LEN+1];
    logic [VW-1:0]       diag_link [MAX_LEN+1];

    assign vld_link[0]  = row_vld;
    assign chr_link[0]  = row_chr;
    assign cost_link[0] = row_left;
    assign diag_link[0] = row_diag;

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        edc_cell #(
            .VW(VW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .init       (init),
            .init_value (VW'(j + 1)),
            .load_sym   (load_en && (load_idx == IW'(j))),
            .sym_in     (load_sym),
            .vld_i      (vld_link[j]),
            .chr_i      (chr_link[j]),
            .left_i     (cost_link[j]),
            .diag_i     (diag_link[j]),
            .vld_o      (vld_link[j+1]),
            .chr_o      (chr_link[j+1]),
            .cost_o     (cost_link[j+1]),
            .diag_o     (diag_link[j+1])
        );
    end

    // the last cell's valid, byte and old cost leave the chain unused
    logic                tail_vld;
    logic [SYMBOL_W-1:0] tail_chr;
    logic [VW-1:0]       tail_diag;
    assign tail_vld  = vld_link[MAX_LEN];
    assign tail_chr  = chr_link[MAX_LEN];
    assign tail_diag = diag_link[MAX_LEN];

    always_comb begin
        sel_cost = cost_link[1];
        for (int k = 0; k < MAX_LEN; k++) begin
            if (sel_idx == IW'(k)) begin
                sel_cost = cost_link[k+1];
            end
        end
    end

endmodule

// ===== hdl/edit_distance_engine_top.sv =====
// Levenshtein edit distance engine: control, first string store, result
// register. Depends on edc_pkg, edc_chain (edc_cell).
//
// Use: send requests on the s_axis channel. command 0 appends symbol to the
// first string, 1 appends it to the second, 2 computes the distance; 3 is
// taken and dropped. Bytes beyond MAX_LEN per string are dropped and set the
// overflow bit of the next result. Each compute request yields exactly one
// m_axis request carrying distance (saturated at 63) and overflow, after
// which both strings and the overflow bit are cleared.
// Append requests are taken whenever the engine is idle. A compute request
// runs the strings through the cell chain, one first-string byte entering per
// cycle and moving one cell per cycle; s_axis_tready is low during that run.
// If the receiver stalls, the result holds in the output register; appends
// for the next pair continue, and a next compute waits at its end until the
// output register frees.
// Reset (aresetn low, synchronous) empties both strings, clears overflow
// and drops any pending result.
module edit_distance_engine_top #(
    parameter int MAX_LEN = edc_pkg::MAX_LEN_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [1:0] command, [9:2] symbol, [15:10] zero
    input  logic [edc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [5:0] distance, [6] overflow, [7] zero
    output logic [edc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import edc_pkg::*;

    localparam int VW = $clog2(MAX_LEN + 1);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int TW = $clog2(2 * MAX_LEN + 1);
    localparam int XW = (VW > DIST_W) ? VW : DIST_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                state_reg, state_next;
    logic [VW-1:0]       first_cnt_reg, first_cnt_next;
    logic [VW-1:0]       second_cnt_reg, second_cnt_next;
    logic                trunc_reg, trunc_next;
    logic [TW-1:0]       step_reg, step_next;
    logic                out_vld_reg, out_vld_next;
    logic [DIST_W-1:0]   dist_reg;
    logic                ovf_reg;
    logic [SYMBOL_W-1:0] first_mem [MAX_LEN];

    logic [CMD_W-1:0]    cmd;
    logic [SYMBOL_W-1:0] sym;
    logic                accept;
    logic                append_first;
    logic                append_second;
    logic                start;
    logic                run_done;
    logic                emit;
    logic                row_vld;
    logic [VW-1:0]       row_idx;
    logic [VW-1:0]       sel_cost;
    logic [VW-1:0]       result;
    logic [XW-1:0]       result_ext;
    logic [DIST_W-1:0]   dist_sat;

    assign cmd    = s_axis_tdata[CMD_W-1:0];
    assign sym    = s_axis_tdata[CMD_W +: SYMBOL_W];
    assign accept = s_axis_tvalid && s_axis_tready;

    assign append_first  = accept && (cmd == CMD_APPEND_FIRST)
                           && (first_cnt_reg != VW'(MAX_LEN));
    assign append_second = accept && (cmd == CMD_APPEND_SECOND)
                           && (second_cnt_reg != VW'(MAX_LEN));
    assign start         = accept && (cmd == CMD_COMPUTE);

    // last cell update lands at step N+M-2, so the answer is stable at N+M-1
    assign run_done = ({1'b0, step_reg} + 1'b1)
                      >= ((TW + 1)'(first_cnt_reg) + (TW + 1)'(second_cnt_reg));
    assign emit     = (state_reg == ST_RUN) && run_done
                      && (!out_vld_reg || m_axis_tready);

    assign row_vld = (state_reg == ST_RUN) && (step_reg < TW'(first_cnt_reg));
    assign row_idx = step_reg[VW-1:0];

    edc_chain #(
        .MAX_LEN (MAX_LEN),
        .VW      (VW),
        .IW      (IW)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .init     (start),
        .load_en  (append_second),
        .load_idx (second_cnt_reg[IW-1:0]),
        .load_sym (sym),
        .row_vld  (row_vld),
        .row_chr  (first_mem[step_reg[IW-1:0]]),
        .row_left (row_idx + 1'b1),
        .row_diag (row_idx),
        .sel_idx  (IW'(second_cnt_reg - 1'b1)),
        .sel_cost (sel_cost)
    );

    // an empty second string leaves only the first string's length
    assign result     = (second_cnt_reg == '0) ? first_cnt_reg : sel_cost;
    assign result_ext = XW'(result);
    assign dist_sat   = (result_ext > XW'(DIST_MAX)) ? DIST_MAX : result_ext[DIST_W-1:0];

    always_comb begin
        state_next      = state_reg;
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        trunc_next      = trunc_reg;
        step_next       = step_reg;
        out_vld_next    = out_vld_reg && !m_axis_tready;
        case (state_reg)
            ST_IDLE: begin
                if (append_first) begin
                    first_cnt_next = first_cnt_reg + 1'b1;
                end
                if (append_second) begin
                    second_cnt_next = second_cnt_reg + 1'b1;
                end
                if (accept && (cmd == CMD_APPEND_FIRST || cmd == CMD_APPEND_SECOND)
                    && !append_first && !append_second) begin
                    trunc_next = 1'b1;
                end
                if (start) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                if (emit) begin
                    state_next      = ST_IDLE;
                    out_vld_next    = 1'b1;
                    first_cnt_next  = '0;
                    second_cnt_next = '0;
                    trunc_next      = 1'b0;
                end else if (!run_done) begin
                    step_next = step_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            trunc_reg      <= 1'b0;
            step_reg       <= '0;
            out_vld_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            trunc_reg      <= trunc_next;
            step_reg       <= step_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (append_first) begin
            first_mem[first_cnt_reg[IW-1:0]] <= sym;
        end
        if (emit) begin
            dist_reg <= dist_sat;
            ovf_reg  <= trunc_reg;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {1'b0, ovf_reg, dist_reg};

endmodule
